// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the classifier RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset
`define UTFC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");
// Antecedent in one cycle implies consequent in the next
`define UTFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");
`else
`define UTFC_ASSERT(label, clk, rst, prop)
`define UTFC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/utfc_pkg.sv =====
// Shared types and constants of the UDP tunnel frame classifier
package utfc_pkg;

   localparam int MAX_FRAME_LEN_DEF = 16384;

   localparam logic [15:0] ETHERTYPE_VLAN = 16'h8100;
   localparam logic [15:0] ETHERTYPE_QINQ = 16'h88A8;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;

   localparam logic [14:0] ETH_TYPE_POS    = 15'd12;
   localparam logic [14:0] PORT_BYTES      = 15'd2;
   localparam logic [14:0] L3_OFFSET_RESET = ETH_TYPE_POS + PORT_BYTES;
   localparam logic [14:0] TAG_LEN         = 15'd4;
   localparam logic [14:0] OFFSET_MAX      = 15'h7FFF;
   localparam logic [3:0]  MIN_IHL         = 4'd5;
   localparam logic [16:0] UDP_HDR_LEN     = 17'd8;

   typedef enum logic [2:0] {
      PH_ETH    = 3'd0,
      PH_IP     = 3'd1,
      PH_UDP    = 3'd2,
      PH_DONE   = 3'd3,
      PH_REJECT = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      CSR_OWN_PORT     = 2'd0,
      CSR_PEER_ADDRESS = 2'd1,
      CSR_REMOTE_PORT  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [15:0] own_port;
      logic [31:0] peer_address;
      logic [15:0] remote_port;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic is_tunnel;
   } verdict_type;

endpackage

// ===== hw/rtl/utfc_parse.sv =====
// Per-byte header parser and end-of-frame verdict
`include "assert_macros.svh"

module utfc_parse #(
   parameter int MAX_FRAME_LEN = utfc_pkg::MAX_FRAME_LEN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [7:0]            frame_byte,
   input  logic                  end_of_frame,
   input  utfc_pkg::cfg_type     cfg,
   output utfc_pkg::verdict_type verdict
);

   localparam int PosCapInt = (MAX_FRAME_LEN < 32767) ? MAX_FRAME_LEN : 32767;
   localparam logic [14:0] POS_CAP = 15'(PosCapInt);

   logic [14:0]         pos_ff, pos_in;
   logic [14:0]         l3off_ff, l3off_in;
   logic [15:0]         etype_ff, etype_in;
   logic [3:0]          ihl_ff, ihl_in;
   logic [7:0]          proto_ff, proto_in;
   logic [31:0]         saddr_ff, saddr_in;
   logic [31:0]         daddr_ff, daddr_in;
   logic [15:0]         sport_ff, sport_in;
   logic [15:0]         dport_ff, dport_in;
   utfc_pkg::phase_type phase_ff, phase_in, phase_step;

   logic [15:0] pos_p1, pos_p2, l3off_ext;
   logic [14:0] rel_ip;
   logic [16:0] udp_start, rel_udp;
   logic [15:0] etype_word;
   logic        clear;
   logic        port_ok, addr_ok;

   assign pos_p1    = {1'b0, pos_ff} + 16'd1;
   assign pos_p2    = {1'b0, pos_ff} + 16'd2;
   assign l3off_ext = {1'b0, l3off_ff};
   assign rel_ip    = pos_ff - l3off_ff;
   assign udp_start = {2'b00, l3off_ff} + {11'd0, ihl_ff, 2'b00};
   assign rel_udp   = {2'b00, pos_ff} - udp_start;
   assign etype_word = {etype_ff[15:8], frame_byte};
   assign clear     = take && end_of_frame;

   // next state
   always_comb begin
      pos_in     = pos_ff;
      l3off_in   = l3off_ff;
      etype_in   = etype_ff;
      ihl_in     = ihl_ff;
      proto_in   = proto_ff;
      saddr_in   = saddr_ff;
      daddr_in   = daddr_ff;
      sport_in   = sport_ff;
      dport_in   = dport_ff;
      phase_step = phase_ff;
      if (take && (pos_ff < POS_CAP)) begin
         pos_in = pos_ff + 15'd1;
         case (phase_ff)
            utfc_pkg::PH_ETH: begin
               if (pos_p2 == l3off_ext) begin
                  etype_in = {frame_byte, 8'h00};
               end else if (pos_p1 == l3off_ext) begin
                  etype_in = etype_word;
                  if ((etype_word == utfc_pkg::ETHERTYPE_VLAN) ||
                      (etype_word == utfc_pkg::ETHERTYPE_QINQ)) begin
                     if (l3off_ff > (utfc_pkg::OFFSET_MAX - utfc_pkg::TAG_LEN)) begin
                        phase_step = utfc_pkg::PH_REJECT;
                     end else begin
                        l3off_in = l3off_ff + utfc_pkg::TAG_LEN;
                     end
                  end else if (etype_word == utfc_pkg::ETHERTYPE_IPV4) begin
                     phase_step = utfc_pkg::PH_IP;
                  end else begin
                     phase_step = utfc_pkg::PH_REJECT;
                  end
               end
            end
            utfc_pkg::PH_IP: begin
               if (rel_ip == 15'd0) begin
                  ihl_in = frame_byte[3:0];
                  if (frame_byte[3:0] < utfc_pkg::MIN_IHL) begin
                     phase_step = utfc_pkg::PH_REJECT;
                  end
               end else if (rel_ip == 15'd9) begin
                  proto_in = frame_byte;
               end else if ((rel_ip >= 15'd12) && (rel_ip < 15'd16)) begin
                  saddr_in = {saddr_ff[23:0], frame_byte};
               end else if ((rel_ip >= 15'd16) && (rel_ip < 15'd20)) begin
                  daddr_in = {daddr_ff[23:0], frame_byte};
                  if (rel_ip == 15'd19) begin
                     phase_step = utfc_pkg::PH_UDP;
                  end
               end
            end
            utfc_pkg::PH_UDP: begin
               if ({2'b00, pos_ff} >= udp_start) begin
                  if (rel_udp < 17'd2) begin
                     sport_in = {sport_ff[7:0], frame_byte};
                  end else if (rel_udp < 17'd4) begin
                     dport_in = {dport_ff[7:0], frame_byte};
                  end else if (rel_udp == (utfc_pkg::UDP_HDR_LEN - 17'd1)) begin
                     phase_step = utfc_pkg::PH_DONE;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      phase_in = phase_step;
      // drop all per-frame state once the verdict is out
      if (clear) begin
         pos_in   = '0;
         l3off_in = utfc_pkg::L3_OFFSET_RESET;
         etype_in = '0;
         ihl_in   = '0;
         proto_in = '0;
         saddr_in = '0;
         daddr_in = '0;
         sport_in = '0;
         dport_in = '0;
         phase_in = utfc_pkg::PH_ETH;
      end
   end

   // outputs: verdict on the final byte, from the phase that byte leaves behind
   always_comb begin
      if (cfg.remote_port != 16'd0) begin
         port_ok = ((sport_ff == cfg.remote_port) && (dport_ff == cfg.own_port)) ||
                   ((sport_ff == cfg.own_port) && (dport_ff == cfg.remote_port));
      end else begin
         port_ok = (sport_ff == cfg.own_port) || (dport_ff == cfg.own_port);
      end
      addr_ok = (cfg.peer_address == 32'd0) ||
                (saddr_ff == cfg.peer_address) || (daddr_ff == cfg.peer_address);
      verdict.valid     = clear;
      verdict.is_tunnel = (phase_step == utfc_pkg::PH_DONE) &&
                          (proto_ff == utfc_pkg::IP_PROTO_UDP) && port_ok && addr_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         l3off_ff <= utfc_pkg::L3_OFFSET_RESET;
         etype_ff <= '0;
         ihl_ff   <= '0;
         proto_ff <= '0;
         saddr_ff <= '0;
         daddr_ff <= '0;
         sport_ff <= '0;
         dport_ff <= '0;
         phase_ff <= utfc_pkg::PH_ETH;
      end else begin
         pos_ff   <= pos_in;
         l3off_ff <= l3off_in;
         etype_ff <= etype_in;
         ihl_ff   <= ihl_in;
         proto_ff <= proto_in;
         saddr_ff <= saddr_in;
         daddr_ff <= daddr_in;
         sport_ff <= sport_in;
         dport_ff <= dport_in;
         phase_ff <= phase_in;
      end
   end

   // tags advance the L3 offset in steps of four from fourteen
   `UTFC_ASSERT(a_l3off_align, clock, reset, (l3off_ff[1:0] == 2'd2) && (l3off_ff >= 15'd14))
   `UTFC_ASSERT(a_pos_cap, clock, reset, pos_ff <= POS_CAP)
   `UTFC_ASSERT(a_done_ihl, clock, reset, (phase_ff != utfc_pkg::PH_DONE) || (ihl_ff >= 4'd5))

endmodule

// ===== hw/rtl/utfc_rsp_buf.sv =====
// Two-entry result buffer between the parser and the result channel
`include "assert_macros.svh"

module utfc_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  utfc_pkg::verdict_type verdict,
   output logic                  full,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_is_tunnel
);

   logic       data_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push          = verdict.valid;
   assign pop           = rsp_valid && !rsp_stall;
   assign full          = (count_ff == 2'd2);
   assign rsp_valid     = (count_ff != 2'd0);
   assign rsp_is_tunnel = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= verdict.is_tunnel;
      end
   end

   `UTFC_ASSERT(a_count_range, clock, reset, count_ff <= 2'd2)
   `UTFC_ASSERT(a_no_push_full, clock, reset, !(push && full))
   `UTFC_ASSERT_NEXT(a_count_grow, clock, reset, push && !pop, count_ff == ($past(count_ff) + 2'd1))

endmodule

// ===== hw/rtl/udp_tunnel_frame_classifier_core.sv =====
// Top level of the UDP tunnel frame classifier
//
// Frame bytes arrive on the req_ channel, one per transfer, starting at the
// destination MAC; req_end_of_frame marks the last byte. Any run of 802.1Q or
// 802.1ad tags is skipped, then an IPv4/UDP header is required. For every
// frame exactly one verdict leaves on the rsp_ channel: rsp_is_tunnel is 1
// when the UDP ports match own_port/remote_port and, if peer_address is
// non-zero, either IP address equals it.
// Throughput: one byte per cycle while req_stall is low. The parser updates
// its header state in the cycle a byte is taken, and the verdict for the
// final byte is written into the result buffer at the edge that takes that
// byte, so rsp_valid is high from the next cycle on.
// The result buffer holds two verdicts. While the receiver stalls, bytes keep
// flowing until two verdicts wait; req_stall is then raised until one is
// taken.
// Reset clears the parser, the buffer and the csr_ registers (all zero).
// Write the csr_ registers only while no frame is in flight.
//
// Register map: 0 own_port, 1 peer_address (first wire byte in [31:24]),
// 2 remote_port. Other indexes are ignored.

module udp_tunnel_frame_classifier_core #(
   parameter int MAX_FRAME_LEN = utfc_pkg::MAX_FRAME_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_end_of_frame,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_tunnel,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   utfc_pkg::cfg_type     cfg_ff, cfg_in;
   utfc_pkg::verdict_type verdict;
   logic                  take;
   logic                  full;

   // a byte transfer happens when a byte is offered and the buffer has room
   assign take      = req_valid && !req_stall;
   assign req_stall = full;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            utfc_pkg::CSR_OWN_PORT:     cfg_in.own_port     = csr_write_data[15:0];
            utfc_pkg::CSR_PEER_ADDRESS: cfg_in.peer_address = csr_write_data;
            utfc_pkg::CSR_REMOTE_PORT:  cfg_in.remote_port  = csr_write_data[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   utfc_parse #(
      .MAX_FRAME_LEN (MAX_FRAME_LEN)
   ) u_parse (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .frame_byte   (req_frame_byte),
      .end_of_frame (req_end_of_frame),
      .cfg          (cfg_ff),
      .verdict      (verdict)
   );

   utfc_rsp_buf u_rsp_buf (
      .clock         (clock),
      .reset         (reset),
      .verdict       (verdict),
      .full          (full),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_is_tunnel (rsp_is_tunnel)
   );

endmodule
